// ===== hdl/header_length_tail_deframer_assert.svh =====
// Assertion macros for the deframer RTL.
// Included by hltd_parser, which carries the concurrent checks; needs no package.
`ifndef HEADER_LENGTH_TAIL_DEFRAMER_ASSERT_SVH
`define HEADER_LENGTH_TAIL_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define HLTD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, disabled in reset.
`define HLTD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== hdl/hltd_pkg.sv =====
// Types and constants for the header/length/tail deframer.
// Used by hltd_parser and header_length_tail_deframer; no dependencies.
package hltd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0   = 3'd0,
    PH_HDR1   = 3'd1,
    PH_HDR2   = 3'd2,
    PH_HDR3   = 3'd3,
    PH_LEN_LO = 3'd4,
    PH_LEN_HI = 3'd5,
    PH_BODY   = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_GOOD_END = 2'd1,
    KIND_BAD_END  = 2'd2
  } kind_t;

  localparam logic [1:0] CFG_HEADER_BYTES  = 2'd0;
  localparam logic [1:0] CFG_TAIL_VALUE    = 2'd1;
  localparam logic [1:0] CFG_CONTENT_LIMIT = 2'd2;

  localparam logic [15:0] CONTENT_LIMIT_RESET = 16'd65534;

  typedef struct packed {
    logic [31:0] header_bytes;
    logic [7:0]  tail_value;
    logic [15:0] content_limit;
  } hltd_cfg_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [15:0] frame_bytes;
  } hltd_result_t;

endpackage

// ===== hdl/header_length_tail_deframer.sv =====
// Top level of the header/length/tail deframer: ports, config registers,
// input and output registers. Depends on hltd_pkg and hltd_parser.
//
//  channel | direction | handshake              | content
//  --------+-----------+------------------------+------------------------------
//  s_axis  | in        | s_axis_tvalid/tready   | tdata: rx_byte
//  m_axis  | out       | m_axis_tvalid/tready   | tdata: payload_byte, frame_bytes;
//          |           |                        | tuser: kind
//  cfg     | in        | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// One byte per cycle sustained while m_axis is not stalled; a body byte's word
// reaches m_axis through the input register, which loads at the accepting edge,
// and then the result register behind the parser.
// The parser's phase, length and position registers advance once per byte.
// rst is synchronous; it returns the parser to hunting, the config registers to
// defaults and clears both valid flags. A stalled m_axis holds its word; the input
// register keeps taking bytes until the word ahead of it cannot move.
module header_length_tail_deframer
  import hltd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [23:8] frame_bytes
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  hltd_cfg_t    cfg;
  hltd_result_t res;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        out_free;
  logic        step;

  logic [1:0]  out_kind;
  logic [7:0]  out_payload;
  logic [15:0] out_frame;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_bytes  <= '0;
      cfg.tail_value    <= '0;
      cfg.content_limit <= CONTENT_LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_HEADER_BYTES:  cfg.header_bytes  <= cfg_data;
        CFG_TAIL_VALUE:    cfg.tail_value    <= cfg_data[7:0];
        CFG_CONTENT_LIMIT: cfg.content_limit <= cfg_data[15:0];
        default: ;  // drop unknown index
      endcase
    end
  end

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign step          = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  hltd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (in_byte),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res.valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // load a new word only when the parser hands one over
  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_kind    <= res.kind;
      out_payload <= res.payload_byte;
      out_frame   <= res.frame_bytes;
    end
  end

  assign m_axis_tdata = {out_frame, out_payload};
  assign m_axis_tuser = out_kind;

endmodule

// ===== hdl/hltd_parser.sv =====
// Frame parser: phase machine, length and position counters, result decode.
// Depends on hltd_pkg and header_length_tail_deframer_assert.svh.
`include "header_length_tail_deframer_assert.svh"

module hltd_parser
  import hltd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   rx_byte,
  input  hltd_cfg_t    cfg,
  output hltd_result_t res
);

  phase_t      phase, phase_next;
  logic [15:0] length_value, length_next;
  logic [15:0] byte_position, position_next;

  logic [15:0] length_full;
  logic        length_ok;
  logic        body_last;

  assign length_full = {rx_byte, length_value[7:0]};
  assign length_ok   = (length_full != 16'd0) &&
                       ({1'b0, length_full} <= ({1'b0, cfg.content_limit} + 17'd1));
  assign body_last   = ({1'b0, byte_position} + 17'd1) >= {1'b0, length_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HDR0;
      length_value  <= '0;
      byte_position <= '0;
    end else begin
      phase         <= phase_next;
      length_value  <= length_next;
      byte_position <= position_next;
    end
  end

  // next state
  always_comb begin
    phase_next    = phase;
    length_next   = length_value;
    position_next = byte_position;
    if (step) begin
      case (phase)
        PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3: begin
          if (rx_byte == cfg.header_bytes[8*phase[1:0] +: 8]) begin
            phase_next = phase_t'(phase + 3'd1);
          end else begin
            phase_next = PH_HDR0;
          end
        end
        PH_LEN_LO: begin
          length_next = {8'd0, rx_byte};
          phase_next  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          length_next = length_full;
          if (length_ok) begin
            phase_next    = PH_BODY;
            position_next = '0;
          end else begin
            phase_next = PH_HDR0;
          end
        end
        PH_BODY: begin
          if (body_last) begin
            phase_next    = PH_HDR0;
            position_next = '0;
          end else begin
            position_next = byte_position + 16'd1;
          end
        end
        default: begin
          // unused code hunts like the first header byte
          phase_next = (rx_byte == cfg.header_bytes[7:0]) ? PH_HDR1 : PH_HDR0;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    res.valid        = step && (phase == PH_BODY);
    res.kind         = KIND_PAYLOAD;
    res.payload_byte = '0;
    res.frame_bytes  = '0;
    if (body_last) begin
      res.kind        = (rx_byte == cfg.tail_value) ? KIND_GOOD_END : KIND_BAD_END;
      res.frame_bytes = length_value - 16'd1;
    end else begin
      res.payload_byte = rx_byte;
    end
  end

  `HLTD_ASSERT_IMP(a_pos_in_body, clk, rst, phase == PH_BODY, byte_position < length_value)
  `HLTD_ASSERT_NEXT(a_end_resyncs, clk, rst, res.valid && res.kind != KIND_PAYLOAD, phase == PH_HDR0)
  `HLTD_ASSERT_NEXT(a_len_enters_body, clk, rst, step && phase == PH_LEN_HI && length_ok, phase == PH_BODY && byte_position == 16'd0)
  `HLTD_ASSERT_IMP(a_body_len_nonzero, clk, rst, phase == PH_BODY, length_value != 16'd0)

endmodule
